// ===== sv/wpr_pkg.sv =====
// wpr_pkg: shared types, constants and byte helpers for the word pattern replace block.
// No dependencies; imported by wpr_word_mem, word_pattern_replace_top and tb_top.
`default_nettype none

package wpr_pkg;

    localparam int WORD_MAX_DEF    = 32;
    localparam int PATTERN_MAX_DEF = 16;
    localparam int CHAR_W          = 8;
    localparam int LEN_W           = 5;    // width of the length registers
    localparam int REG_W           = 64;   // width of the configuration data
    localparam int CFG_AW          = 3;    // register index width
    localparam int BUF_BYTES       = 16;   // bytes held by a pattern or replacement pair
    localparam int BUF_IW          = 4;    // index width into such a pair

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;

    typedef enum logic [CFG_AW-1:0] {
        REG_PAT_LO  = 3'd0,
        REG_PAT_HI  = 3'd1,
        REG_PAT_LEN = 3'd2,
        REG_REP_LO  = 3'd3,
        REG_REP_HI  = 3'd4,
        REG_REP_LEN = 3'd5,
        REG_ICASE   = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP_RD,
        S_CMP_CHK,
        S_EMIT_SEL,
        S_EMIT_DAT
    } t_state;

    function automatic logic is_word(input logic [CHAR_W-1:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LO_A && c <= CH_LO_Z) ||
               (c >= CH_UP_A && c <= CH_UP_Z) || (c == CH_DASH);
    endfunction

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c,
                                               input logic icase);
        if (icase && c >= CH_UP_A && c <= CH_UP_Z) begin
            return c | CASE_BIT;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/wpr_word_mem.sv =====
// wpr_word_mem: word buffer, one write port and one read port with registered data.
// Depends on wpr_pkg for the byte width.
`default_nettype none

module wpr_word_mem
    import wpr_pkg::*;
#(
    parameter int DEPTH = WORD_MAX_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [CHAR_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [CHAR_W-1:0] o_rdata
);

    logic [CHAR_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/word_pattern_replace_top.sv =====
// word_pattern_replace_top: rewrites words of a byte stream that contain a pattern.
// Depends on wpr_pkg and wpr_word_mem.
//
//  Channel   Dir  Handshake                    Payload
//  s_axis    in   i_s_axis_tvalid/o_..tready   tdata[7:0] in_char
//  m_axis    out  o_m_axis_tvalid/i_..tready   tdata[7:0] out_char, tlast word_end
//  cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_addr register index, i_cfg_data value
//
// Sequencing: a word byte is stored in S_IDLE; while no match is found yet it then starts a
//  compare run over the pattern bytes; each compare step is a buffer read (S_CMP_RD) followed
//  by one byte compare (S_CMP_CHK) in the single shared compare unit. A closing byte of a matched
//  word starts emission: each copied word byte passes S_EMIT_SEL then S_EMIT_DAT (buffer read),
//  and each replacement byte, the skip of the pattern and the newline take a step in S_EMIT_SEL.
// s_axis is ready only while the sequencer is idle; config is always ready.
// Reset is synchronous, active low; the word buffer itself is not cleared.
// A stalled m_axis holds the output register and freezes emission; the final newline
//  may still wait in the output register while the next input byte is taken.
`default_nettype none

module word_pattern_replace_top
    import wpr_pkg::*;
#(
    parameter int WORD_MAX    = WORD_MAX_DEF,
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input stream
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [CHAR_W-1:0] i_s_axis_tdata,   // [7:0] in_char
    // output stream
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic      [CHAR_W-1:0] o_m_axis_tdata,   // [7:0] out_char
    output logic                   o_m_axis_tlast,   // word_end
    // configuration writes
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [REG_W-1:0]  i_cfg_data
);

    localparam int LW = $clog2(WORD_MAX + 1);      // word length, counts to WORD_MAX
    localparam int AW = $clog2(WORD_MAX);          // buffer address
    localparam int PW = $clog2(PATTERN_MAX + 1);   // active pattern length and index
    localparam int CW = (LW > PW) ? LW : PW;       // common width for length arithmetic

    // ---------------- registers ----------------
    t_state              r_state, n_state;
    logic [REG_W-1:0]    r_pat_lo, r_pat_hi, r_rep_lo, r_rep_hi;
    logic [LEN_W-1:0]    r_pat_len, r_rep_len;
    logic                r_icase;

    logic [LW-1:0]       r_len, n_len;
    logic                r_ovf, n_ovf;
    logic                r_match, n_match;
    logic [AW-1:0]       r_mstart, n_mstart;
    logic [AW-1:0]       r_base, n_base;
    logic [PW-1:0]       r_idx, n_idx;
    logic [LW-1:0]       r_p, n_p;
    logic [LEN_W-1:0]    r_r, n_r;
    logic                r_ov, n_ov;
    logic [CHAR_W-1:0]   r_ochar, n_ochar;
    logic                r_oend, n_oend;

    // ---------------- derived values ----------------
    logic [PW-1:0]          w_plen;
    logic [LEN_W-1:0]       w_rlen;
    logic [2*REG_W-1:0]     w_pat_all, w_rep_all;
    logic [CHAR_W-1:0]      w_pat_byte, w_rep_byte, w_rdata;
    logic [AW-1:0]          w_raddr;
    logic                   w_acc, w_is_word, w_store, w_full, w_cmp_go, w_emit_go;
    logic                   w_slot_free, w_hit, w_last, w_at_end, w_at_match, w_rep_more;
    logic [LW-1:0]          w_len_inc;

    // pattern length 0 acts as 1, anything past PATTERN_MAX as PATTERN_MAX
    always_comb begin
        if (r_pat_len == '0) begin
            w_plen = PW'(1);
        end else if (r_pat_len > LEN_W'(PATTERN_MAX)) begin
            w_plen = PW'(PATTERN_MAX);
        end else begin
            w_plen = PW'(r_pat_len);
        end
    end

    assign w_rlen     = (r_rep_len > LEN_W'(BUF_BYTES)) ? LEN_W'(BUF_BYTES) : r_rep_len;
    assign w_pat_all  = {r_pat_hi, r_pat_lo};
    assign w_rep_all  = {r_rep_hi, r_rep_lo};
    assign w_pat_byte = w_pat_all[CHAR_W*BUF_IW'(r_idx) +: CHAR_W];
    assign w_rep_byte = w_rep_all[CHAR_W*BUF_IW'(r_r) +: CHAR_W];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_word       = is_word(i_s_axis_tdata);
    assign w_full          = (r_len == LW'(WORD_MAX));
    assign w_store         = w_acc && w_is_word && !r_ovf && !w_full;
    assign w_len_inc       = r_len + LW'(1);
    assign w_cmp_go        = w_store && !r_match && (CW'(w_len_inc) >= CW'(w_plen));
    assign w_emit_go       = w_acc && !w_is_word && (r_len != '0) && !r_ovf && r_match;

    assign w_slot_free = !r_ov || i_m_axis_tready;
    // shared compare unit: one buffered byte against one pattern byte
    assign w_hit       = fold(w_rdata, r_icase) == fold(w_pat_byte, r_icase);
    assign w_last      = (r_idx == w_plen - PW'(1));
    assign w_at_end    = (r_p == r_len);
    assign w_at_match  = (r_p == LW'(r_mstart));
    assign w_rep_more  = (r_r < w_rlen);

    assign w_raddr = (r_state == S_CMP_RD || r_state == S_CMP_CHK) ?
                     AW'(r_base + AW'(r_idx)) : AW'(r_p);

    wpr_word_mem #(
        .DEPTH (WORD_MAX),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (AW'(r_len)),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_cmp_go) begin
                    n_state = S_CMP_RD;
                end else if (w_emit_go) begin
                    n_state = S_EMIT_SEL;
                end
            end
            S_CMP_RD: begin
                n_state = S_CMP_CHK;
            end
            S_CMP_CHK: begin
                n_state = (!w_hit || w_last) ? S_IDLE : S_CMP_RD;
            end
            S_EMIT_SEL: begin
                if (w_at_end) begin
                    if (w_slot_free) begin
                        n_state = S_IDLE;
                    end
                end else if (!w_at_match) begin
                    n_state = S_EMIT_DAT;
                end
            end
            S_EMIT_DAT: begin
                if (w_slot_free) begin
                    n_state = S_EMIT_SEL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_match  = r_match;
        n_mstart = r_mstart;
        n_base   = r_base;
        n_idx    = r_idx;
        n_p      = r_p;
        n_r      = r_r;
        n_ov     = r_ov && !i_m_axis_tready;
        n_ochar  = r_ochar;
        n_oend   = r_oend;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && w_is_word) begin
                    if (w_store) begin
                        n_len  = w_len_inc;
                        n_base = AW'(CW'(w_len_inc) - CW'(w_plen));
                        n_idx  = '0;
                    end else if (!r_ovf) begin
                        n_ovf = 1'b1;      // word longer than the buffer
                    end
                end else if (w_emit_go) begin
                    n_p = '0;
                    n_r = '0;
                end else if (w_acc) begin
                    n_len    = '0;
                    n_ovf    = 1'b0;
                    n_match  = 1'b0;
                    n_mstart = '0;
                end
            end
            S_CMP_RD: begin
            end
            S_CMP_CHK: begin
                if (w_hit && w_last) begin
                    n_match  = 1'b1;
                    n_mstart = r_base;
                end else if (w_hit) begin
                    n_idx = r_idx + PW'(1);
                end
            end
            S_EMIT_SEL: begin
                if (w_at_end) begin
                    if (w_slot_free) begin
                        n_ov     = 1'b1;
                        n_ochar  = CH_NEWLINE;
                        n_oend   = 1'b1;
                        n_len    = '0;
                        n_ovf    = 1'b0;
                        n_match  = 1'b0;
                        n_mstart = '0;
                    end
                end else if (w_at_match) begin
                    if (!w_rep_more) begin
                        n_p = LW'(CW'(r_p) + CW'(w_plen));   // skip the occurrence
                    end else if (w_slot_free) begin
                        n_ov    = 1'b1;
                        n_ochar = w_rep_byte;
                        n_oend  = 1'b0;
                        n_r     = r_r + LEN_W'(1);
                    end
                end
            end
            S_EMIT_DAT: begin
                if (w_slot_free) begin
                    n_ov    = 1'b1;
                    n_ochar = w_rdata;
                    n_oend  = 1'b0;
                    n_p     = r_p + LW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_match  <= 1'b0;
            r_mstart <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_ovf    <= n_ovf;
            r_match  <= n_match;
            r_mstart <= n_mstart;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_idx   <= n_idx;
        r_p     <= n_p;
        r_r     <= n_r;
        r_ochar <= n_ochar;
        r_oend  <= n_oend;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= LEN_W'(1);
            r_rep_lo  <= '0;
            r_rep_hi  <= '0;
            r_rep_len <= LEN_W'(1);
            r_icase   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                REG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                REG_PAT_LEN: r_pat_len <= i_cfg_data[LEN_W-1:0];
                REG_REP_LO:  r_rep_lo  <= i_cfg_data;
                REG_REP_HI:  r_rep_hi  <= i_cfg_data;
                REG_REP_LEN: r_rep_len <= i_cfg_data[LEN_W-1:0];
                REG_ICASE:   r_icase   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_ochar;
    assign o_m_axis_tlast  = r_oend;

    // ---------------- assertions ----------------
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(WORD_MAX))
        else $error("word length past buffer depth");

    a_emit_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_SEL || r_state == S_EMIT_DAT) |-> (r_match && !r_ovf && r_len != '0))
        else $error("emitting a word that has no match");

    a_emit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_SEL || r_state == S_EMIT_DAT) |-> r_p <= r_len)
        else $error("emit position past word end");

    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP_RD) |-> (CW'(r_base) + CW'(r_idx) < CW'(r_len)))
        else $error("compare reads outside the stored word");

    a_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tdata == CH_NEWLINE))
        else $error("word end without newline");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_SEL && w_at_end && w_slot_free) |=> (r_len == '0 && !r_match))
        else $error("word state not cleared after emission");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for word_pattern_replace_top.
// Depends on wpr_pkg and the RTL of word_pattern_replace_top, which in turn needs wpr_word_mem.
// Byte streams in, rewritten words out, checked against an in-bench rewrite predictor.

module tb_top
    import wpr_pkg::*;
;

    // Pause before a register write once nothing is expected: covers the longest
    // compare run that an input byte can start.
    localparam int DRAIN_PAD      = 2 * PATTERN_MAX_DEF + 8;
    // Cycles without any transaction on any channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 2000;
    // Random settings, each followed by a burst of text.
    localparam int N_PHASES       = 8;
    localparam int PHASE_BYTES    = 32;
    localparam int MAX_PRINTED    = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } out_beat_t;

    // ------------------------------------------------------------------
    // Rewrite predictor and scoreboard: holds its own copy of the registers
    // and of the word being collected, and queues the bytes that the
    // block must emit for each word that ends.
    // ------------------------------------------------------------------
    class rewrite_scoreboard;
        logic [REG_W-1:0]  pat_lo, pat_hi, rep_lo, rep_hi;
        logic [LEN_W-1:0]  pat_len, rep_len;
        logic              icase;

        logic [CHAR_W-1:0] word_buf [WORD_MAX_DEF];
        int                word_len;
        bit                too_long;
        bit                found;
        int                hit_at;

        out_beat_t         rewritten_q [$];

        int n_errors;
        int n_bytes_in;
        int n_words_out;
        int n_long_dropped;

        function new();
            pat_lo  = '0;
            pat_hi  = '0;
            rep_lo  = '0;
            rep_hi  = '0;
            pat_len = LEN_W'(1);
            rep_len = LEN_W'(1);
            icase   = 1'b0;
            clear_word();
        endfunction

        static function bit is_word_char(logic [CHAR_W-1:0] c);
            return (c >= CH_0 && c <= CH_9) || (c >= CH_LO_A && c <= CH_LO_Z) ||
                   (c >= CH_UP_A && c <= CH_UP_Z) || (c == CH_DASH);
        endfunction

        function logic [CHAR_W-1:0] lower(logic [CHAR_W-1:0] c);
            if (icase && c >= CH_UP_A && c <= CH_UP_Z) begin
                return c + CASE_BIT;
            end
            return c;
        endfunction

        function logic [CHAR_W-1:0] pick(logic [REG_W-1:0] lo, logic [REG_W-1:0] hi,
                                         int i);
            return (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
        endfunction

        // Length register clamped to what the block uses.
        function int used_pat_len();
            if (pat_len == 0) begin
                return 1;
            end
            return (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len);
        endfunction

        function void clear_word();
            word_len = 0;
            too_long = 1'b0;
            found    = 1'b0;
            hit_at   = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [REG_W-1:0] d);
            case (idx)
                REG_PAT_LO:  pat_lo  = d;
                REG_PAT_HI:  pat_hi  = d;
                REG_PAT_LEN: pat_len = d[LEN_W-1:0];
                REG_REP_LO:  rep_lo  = d;
                REG_REP_HI:  rep_hi  = d;
                REG_REP_LEN: rep_len = d[LEN_W-1:0];
                REG_ICASE:   icase   = d[0];
                default: ;
            endcase
        endfunction

        // One accepted input byte: extend the word and look for the pattern,
        // or close the word and queue its rewritten form.
        function void take_byte(logic [CHAR_W-1:0] c);
            int        plen;
            int        rlen;
            int        base;
            int        p;
            bit        hit;
            out_beat_t b;
            n_bytes_in++;
            if (is_word_char(c)) begin
                if (too_long) begin
                    return;
                end
                if (word_len >= WORD_MAX_DEF) begin
                    too_long = 1'b1;
                    n_long_dropped++;
                    return;
                end
                word_buf[word_len] = c;
                word_len++;
                if (!found) begin
                    plen = used_pat_len();
                    if (word_len >= plen) begin
                        base = word_len - plen;
                        hit  = 1'b1;
                        for (int i = 0; i < plen; i++) begin
                            if (lower(word_buf[base+i]) != lower(pick(pat_lo, pat_hi, i))) begin
                                hit = 1'b0;
                            end
                        end
                        if (hit) begin
                            found  = 1'b1;
                            hit_at = base;
                        end
                    end
                end
                return;
            end
            // separator: only a complete word that matched is emitted
            if (word_len > 0 && !too_long && found) begin
                plen   = used_pat_len();
                rlen   = (rep_len > 16) ? 16 : int'(rep_len);
                b.last = 1'b0;
                p      = 0;
                while (p < word_len) begin
                    if (p == hit_at) begin
                        for (int r = 0; r < rlen; r++) begin
                            b.ch = pick(rep_lo, rep_hi, r);
                            rewritten_q.push_back(b);
                        end
                        p += plen;
                    end else begin
                        b.ch = word_buf[p];
                        rewritten_q.push_back(b);
                        p++;
                    end
                end
                b.ch   = CH_NEWLINE;
                b.last = 1'b1;
                rewritten_q.push_back(b);
                n_words_out++;
            end
            clear_word();
        endfunction

        task report_mismatch(string what);
            n_errors++;
            if (n_errors <= MAX_PRINTED) begin
                $display("tb_top: mismatch: %s", what);
            end
        endtask

        task check_beat(logic [CHAR_W-1:0] ch, logic last);
            out_beat_t want;
            if (rewritten_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b", ch, last));
                return;
            end
            want = rewritten_q.pop_front();
            if (ch !== want.ch) begin
                report_mismatch($sformatf("out_char %02h, expected %02h", ch, want.ch));
            end
            if (last !== want.last) begin
                report_mismatch($sformatf("word_end %0b, expected %0b on byte %02h",
                                          last, want.last, want.ch));
            end
        endtask

        function int pending();
            return rewritten_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [CHAR_W-1:0] i_s_axis_tdata;    // [7:0] in_char
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [CHAR_W-1:0] o_m_axis_tdata;    // [7:0] out_char
    logic              o_m_axis_tlast;    // word_end
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [REG_W-1:0]  i_cfg_data;

    word_pattern_replace_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    rewrite_scoreboard sb = new();

    // Idling intensity in percent, shared by both sides; 0 gives a clean stretch.
    int idle_pct   = 0;
    int stall_left = 0;
    int n_settings = 0;

    // Current pattern as the stimulus sees it, for building matching words.
    logic [CHAR_W-1:0] pat_bytes [BUF_BYTES];
    int                pat_used;
    bit                pat_all_word;
    bit                cur_icase;

    wire s_fire = i_s_axis_tvalid && o_s_axis_tready;
    wire m_fire = o_m_axis_tvalid && i_m_axis_tready;
    wire c_fire = i_cfg_valid && o_cfg_ready;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Output side: every accepted transaction is checked against the oldest expectation.
    // Values are read at the edge before any nonblocking update lands.
    always @(posedge i_clk) begin
        if (i_rst_n && m_fire) begin
            sb.check_beat(o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    // Receiver back-pressure: random stalls.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 3) begin
            stall_left = $urandom_range(1, 16) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: any transaction on any channel restarts the count.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || s_fire || m_fire || c_fire) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top: watchdog expired, %0d results outstanding", sb.pending());
        $display("tb_top: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] rand_word_char();
        int k;
        k = $urandom_range(0, 62);
        if (k < 10) begin
            return CH_0 + CHAR_W'(k);
        end
        if (k < 36) begin
            return CH_LO_A + CHAR_W'(k - 10);
        end
        if (k < 62) begin
            return CH_UP_A + CHAR_W'(k - 36);
        end
        return CH_DASH;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_separator();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(0, 255));
        while (rewrite_scoreboard::is_word_char(c)) begin
            c = CHAR_W'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // Random case flip on letters, only when the compare ignores case.
    function automatic logic [CHAR_W-1:0] vary_case(logic [CHAR_W-1:0] c);
        bit letter;
        letter = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
        if (cur_icase && letter && $urandom_range(0, 1) == 1) begin
            return c ^ CASE_BIT;
        end
        return c;
    endfunction

    // One input transaction. tvalid stays high on return so that a following
    // byte carries on without a gap; it is lowered only for an idle burst.
    task automatic send_byte(logic [CHAR_W-1:0] c);
        int gap;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 16);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.take_byte(c);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    // A word of random word bytes, optionally carrying the pattern (or a pattern
    // cut short by one byte, a near miss), then one or two separators.
    task automatic send_word(int len, bit with_pat);
        logic [CHAR_W-1:0] w [$];
        int                pos;
        int                cut;
        for (int i = 0; i < len; i++) begin
            w.push_back(rand_word_char());
        end
        if (with_pat && pat_all_word) begin
            cut = ($urandom_range(0, 4) == 0 && pat_used > 1) ? 1 : 0;
            pos = $urandom_range(0, len);
            for (int i = pat_used - 1 - cut; i >= 0; i--) begin
                w.insert(pos, vary_case(pat_bytes[i]));
            end
        end
        foreach (w[i]) begin
            send_byte(w[i]);
        end
        send_byte(rand_separator());
        if ($urandom_range(0, 5) == 0) begin
            send_byte(rand_separator());   // empty word
        end
    endtask

    // Let every expected result come out and any compare run finish.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [REG_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, d);
    endtask

    // Writes all seven registers with the block idle, and keeps a copy of the
    // pattern for the word builder.
    task automatic load_config(logic [REG_W-1:0] pl, logic [REG_W-1:0] ph,
                               logic [REG_W-1:0] plen, logic [REG_W-1:0] rl,
                               logic [REG_W-1:0] rh, logic [REG_W-1:0] rlen,
                               logic [REG_W-1:0] ic);
        int n;
        drain();
        write_reg(REG_PAT_LO,  pl);
        write_reg(REG_PAT_HI,  ph);
        write_reg(REG_PAT_LEN, plen);
        write_reg(REG_REP_LO,  rl);
        write_reg(REG_REP_HI,  rh);
        write_reg(REG_REP_LEN, rlen);
        write_reg(REG_ICASE,   ic);
        i_cfg_valid <= 1'b0;
        n = int'(plen[LEN_W-1:0]);
        pat_used     = (n == 0) ? 1 : (n > PATTERN_MAX_DEF ? PATTERN_MAX_DEF : n);
        cur_icase    = ic[0];
        pat_all_word = 1'b1;
        for (int i = 0; i < BUF_BYTES; i++) begin
            pat_bytes[i] = (i < 8) ? pl[8*i +: 8] : ph[8*(i-8) +: 8];
            if (i < pat_used && !rewrite_scoreboard::is_word_char(pat_bytes[i])) begin
                pat_all_word = 1'b0;
            end
        end
        n_settings++;
    endtask

    // Random setting for one phase; the first four pin the length extremes:
    // shortest, longest, zero (taken as one / no replacement) and oversized.
    task automatic random_setting(int ph);
        logic [REG_W-1:0] pl, phi, plen, rlen;
        int               used;
        logic [CHAR_W-1:0] b;
        plen = REG_W'($urandom_range(1, 16));
        rlen = REG_W'($urandom_range(0, 16));
        case (ph)
            0: begin plen = 1;  rlen = 1;  end
            1: begin plen = 16; rlen = 16; end
            2: begin plen = 0;  rlen = 0;  end
            3: begin
                plen = REG_W'($urandom_range(17, 31));
                rlen = REG_W'($urandom_range(17, 31));
            end
            6: plen = REG_W'($urandom_range(1, 2));
            default: ;
        endcase
        // junk above the length field must be ignored
        if (ph == 3 || ph == 5) begin
            plen = ({$urandom, $urandom} & ~64'h1F) | plen;
            rlen = ({$urandom, $urandom} & ~64'h1F) | rlen;
        end
        used = (plen[LEN_W-1:0] == 0) ? 1 :
               (plen[LEN_W-1:0] > PATTERN_MAX_DEF ? PATTERN_MAX_DEF : int'(plen[LEN_W-1:0]));
        pl  = '0;
        phi = '0;
        for (int i = 0; i < BUF_BYTES; i++) begin
            // phase 6 uses raw bytes, usually not word bytes, so a match is rare
            b = (ph == 6 || i >= used) ? CHAR_W'($urandom_range(0, 255)) : rand_word_char();
            if (i < 8) begin
                pl[8*i +: 8] = b;
            end else begin
                phi[8*(i-8) +: 8] = b;
            end
        end
        load_config(pl, phi, plen, {$urandom, $urandom}, {$urandom, $urandom}, rlen,
                    (ph % 2 == 1) ? {$urandom, $urandom} | 64'h1 : {$urandom, $urandom} & ~64'h1);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int target;
        int r;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_addr      <= REG_PAT_LO;
        i_cfg_data      <= '0;
        pat_used     = 1;
        pat_all_word = 1'b0;
        cur_icase    = 1'b0;
        for (int i = 0; i < BUF_BYTES; i++) begin
            pat_bytes[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        idle_pct = 20;
        // reset pattern is a NUL byte, which never sits inside a word
        send_text("a-9 ");
        // pattern "Ab", replacement "xyz", case ignored; second word has two hits
        load_config(64'h6241, '0, 2, 64'h7A7978, '0, 3, 1);
        send_text("zaB.");
        send_text("-AB-AB,");
        // no replacement bytes; top-bit separator, then an empty word
        load_config(64'h6241, '0, 2, 64'h7A7978, '0, 0, 1);
        send_text("Ab");
        send_byte(8'hFF);
        send_byte(8'h00);
        // pattern length 0 acts as 1 ("A"), oversized replacement clamps to 16 bytes
        load_config(64'h6241, '0, 0, {$urandom, $urandom}, {$urandom, $urandom}, 20, 0);
        send_text("A!");

        // Random part: mostly well-formed words with the pattern, some long words
        // that overflow the buffer, the odd raw byte
        for (int ph = 0; ph < N_PHASES; ph++) begin
            random_setting(ph);
            idle_pct = (ph == 2 || ph == N_PHASES - 1) ? 0 : $urandom_range(5, 35);
            target = sb.n_bytes_in + PHASE_BYTES;
            while (sb.n_bytes_in < target) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    send_byte(CHAR_W'($urandom_range(0, 255)));
                end else if (r == 1) begin
                    send_word($urandom_range(25, 40), 1'b1);
                end else begin
                    send_word($urandom_range(1, 12), $urandom_range(0, 9) < 7);
                end
            end
        end

        // Wind down: everything accepted, wait for the last results and a margin
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (2 * DRAIN_PAD) @(posedge i_clk);
        while (sb.pending() > 0) begin
            sb.report_mismatch("expected result never arrived");
            void'(sb.rewritten_q.pop_front());
        end

        $display("tb_top: %0d bytes over %0d register settings, %0d words rewritten",
                 sb.n_bytes_in, n_settings, sb.n_words_out);
        $display("tb_top: %0d overlong words dropped, %0d mismatches",
                 sb.n_long_dropped, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
